FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. They vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/ban_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ban_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 1024;

  localparam int CHAR_W  = 8;
  localparam int WBYTE_W = 7;
  localparam int IDX_W   = 10;
  localparam int TOTAL_W = 10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_TOP   = 8'd127;

  localparam logic [WBYTE_W-1:0] WB_ZERO  = 7'h00;
  localparam logic [WBYTE_W-1:0] WB_SPACE = 7'h20;
  localparam logic [WBYTE_W-1:0] WB_DOT   = 7'h2E;
  localparam logic [WBYTE_W-1:0] WB_EQUAL = 7'h3D;

  // One buffer write as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0]   widx;
    logic [WBYTE_W-1:0] wbyte;
    logic [TOTAL_W-1:0] total;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/boot_argument_normalizer.sv
// Channel | Direction | Ports                                         | Item
// in_     | input     | in_valid, in_ready, in_char_in                | one raw byte
// out_    | output    | out_valid, out_ready, out_write_index,        | one buffer write
//         |           | out_write_byte, out_entry_total,              |
//         |           | out_last_of_run, out_line_done                |
// Each byte is decoded in the cycle it is accepted; its writes appear in the next cycle.
// A byte gives no write or up to three; the next byte waits while the three-entry result
// register drains, and is taken in the cycle that its last write is accepted.
// Reset is synchronous and active low: empty buffer, no entries, no results pending.
// A stalled output holds its write and blocks the input until the last write is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module boot_argument_normalizer
  import ban_pkg::*;
#(
  parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [CHAR_W-1:0]  in_char_in,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [IDX_W-1:0]   out_write_index,
  output logic [WBYTE_W-1:0] out_write_byte,
  output logic [TOTAL_W-1:0] out_entry_total,
  output logic               out_last_of_run,
  output logic               out_line_done
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int XW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [PW-1:0] LIMIT = PW'(BUFFER_BYTES - 2);

  // Line state
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic               eq_r, eq_nxt;
  logic               pwz_r, pwz_nxt;
  logic               full_r, full_nxt;

  // Result register
  res_t               res_r [3];
  res_t               res_nxt [3];
  logic [1:0]         num_r;
  logic [1:0]         rd_r;
  logic               line_r;
  logic [1:0]         n_nxt;
  logic               line_nxt;

  logic               in_fire, out_fire, drain_last;
  logic [PW-1:0]      pos_c;
  logic               full_now, add_eq, ins, eq_c;
  logic [WBYTE_W-1:0] norm;

  function automatic res_t mk(input logic [PW-1:0] p, input logic [WBYTE_W-1:0] b,
                              input logic [TOTAL_W-1:0] t);
    logic [XW-1:0] e;
    res_t r;
    e       = XW'(p);
    r.widx  = e[IDX_W-1:0];
    r.wbyte = b;
    r.total = t;
    return r;
  endfunction

  assign out_valid  = (num_r != 2'd0);
  assign out_fire   = out_valid && out_ready;
  assign drain_last = out_fire && (rd_r == num_r - 2'd1);
  assign in_ready   = !out_valid || drain_last;
  assign in_fire    = in_valid && in_ready;

  assign out_write_index = res_r[rd_r].widx;
  assign out_write_byte  = res_r[rd_r].wbyte;
  assign out_entry_total = res_r[rd_r].total;
  assign out_last_of_run = (rd_r == num_r - 2'd1);
  assign out_line_done   = line_r;

  always_comb begin
    pos_c      = pos_r;
    full_now   = full_r || (pos_r >= LIMIT);
    add_eq     = 1'b0;
    ins        = 1'b0;
    eq_c       = eq_r || (in_char_in == CH_EQUAL);
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    eq_nxt     = eq_r;
    pwz_nxt    = pwz_r;
    full_nxt   = full_r;
    n_nxt      = 2'd0;
    line_nxt   = 1'b0;
    res_nxt[0] = mk(pos_r, WB_ZERO, cnt_r);
    res_nxt[1] = res_nxt[0];
    res_nxt[2] = res_nxt[0];

    if ((in_char_in < CH_SPACE) || (in_char_in > CH_TOP)) begin
      if (in_char_in == CH_NL || in_char_in == CH_CR || in_char_in == CH_TAB) begin
        norm = WB_SPACE;
      end else begin
        norm = WB_DOT;
      end
    end else begin
      norm = in_char_in[WBYTE_W-1:0];
    end

    if (in_char_in == CH_NUL) begin
      // Terminator: close the open entry, then write the double zero.
      if (pos_r > LIMIT) begin
        pos_c = LIMIT;
      end
      add_eq   = !full_now && !eq_r && !pwz_r;
      line_nxt = 1'b1;
      if (!full_now && (eq_r || !pwz_r)) begin
        cnt_nxt = cnt_r + TOTAL_W'(1);
      end
      if (add_eq) begin
        res_nxt[0] = mk(pos_c, WB_EQUAL, cnt_nxt);
        res_nxt[1] = mk(pos_c + PW'(1), WB_ZERO, cnt_nxt);
        res_nxt[2] = mk(pos_c + PW'(2), WB_ZERO, cnt_nxt);
        n_nxt      = 2'd3;
        pos_nxt    = pos_c + PW'(2);
      end else begin
        res_nxt[0] = mk(pos_c, WB_ZERO, cnt_nxt);
        res_nxt[1] = mk(pos_c + PW'(1), WB_ZERO, cnt_nxt);
        n_nxt      = 2'd2;
        pos_nxt    = pos_c + PW'(1);
      end
      eq_nxt   = 1'b0;
      pwz_nxt  = 1'b1;
      full_nxt = (pos_nxt >= LIMIT);
    end else if (full_now) begin
      full_nxt = 1'b1;
    end else if (norm == WB_SPACE) begin
      // Leading or repeated spaces leave everything as it was.
      if (!pwz_r) begin
        ins     = !eq_c && ((pos_r + PW'(1)) < LIMIT);
        cnt_nxt = cnt_r + TOTAL_W'(1);
        if (ins) begin
          res_nxt[0] = mk(pos_r, WB_EQUAL, cnt_r);
          res_nxt[1] = mk(pos_r + PW'(1), WB_ZERO, cnt_nxt);
          n_nxt      = 2'd2;
          pos_nxt    = pos_r + PW'(2);
        end else begin
          res_nxt[0] = mk(pos_r, WB_ZERO, cnt_nxt);
          n_nxt      = 2'd1;
          pos_nxt    = pos_r + PW'(1);
        end
        eq_nxt   = 1'b0;
        pwz_nxt  = 1'b1;
        full_nxt = (pos_nxt >= LIMIT);
      end
    end else begin
      res_nxt[0] = mk(pos_r, norm, cnt_r);
      n_nxt      = 2'd1;
      pos_nxt    = pos_r + PW'(1);
      eq_nxt     = eq_c;
      pwz_nxt    = 1'b0;
      full_nxt   = (pos_nxt >= LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cnt_r  <= '0;
      eq_r   <= 1'b0;
      pwz_r  <= 1'b1;
      full_r <= 1'b0;
      num_r  <= 2'd0;
      rd_r   <= 2'd0;
    end else begin
      if (in_fire) begin
        pos_r  <= pos_nxt;
        cnt_r  <= cnt_nxt;
        eq_r   <= eq_nxt;
        pwz_r  <= pwz_nxt;
        full_r <= full_nxt;
      end
      if (in_fire && n_nxt != 2'd0) begin
        num_r <= n_nxt;
        rd_r  <= 2'd0;
      end else if (drain_last) begin
        num_r <= 2'd0;
        rd_r  <= 2'd0;
      end else if (out_fire) begin
        rd_r <= rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_nxt != 2'd0) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
      res_r[2] <= res_nxt[2];
      line_r   <= line_nxt;
    end
  end

  `ASSERT_CLK(a_idle_ready, clk, rst_n, !out_valid |-> in_ready)
  `ASSERT_NEVER(a_rd_in_range, clk, rst_n, out_valid && (rd_r >= num_r))
  `ASSERT_CLK(a_full_matches_pos, clk, rst_n, full_r == (pos_r >= LIMIT))
  `ASSERT_NEVER(a_pos_in_buffer, clk, rst_n, pos_r > LIMIT + PW'(1))
  `ASSERT_CLK(a_results_follow, clk, rst_n, (in_fire && n_nxt != 2'd0) |=> out_valid)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ban_pkg::*;

  localparam int LIMIT        = DEFAULT_BUFFER_BYTES - 2;
  localparam int RANDOM_ITEMS = 260;
  localparam int DRAIN_CYCLES = 20000;

  typedef struct {
    logic [IDX_W-1:0]   widx;
    logic [WBYTE_W-1:0] wbyte;
    logic [TOTAL_W-1:0] total;
    logic               last;
    logic               done;
  } buf_write_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CHAR_W-1:0]  in_char_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IDX_W-1:0]   out_write_index;
  logic [WBYTE_W-1:0] out_write_byte;
  logic [TOTAL_W-1:0] out_entry_total;
  logic               out_last_of_run;
  logic               out_line_done;

  buf_write_t pending_writes[$];
  int fail_count = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;

  // Shadow copy of the normaliser state.
  int unsigned        shadow_pos = 0;
  logic [TOTAL_W-1:0] shadow_entries = '0;
  bit                 shadow_equal = 1'b0;
  bit                 shadow_zero = 1'b1;
  bit                 shadow_full = 1'b0;

  boot_argument_normalizer #(
    .BUFFER_BYTES(DEFAULT_BUFFER_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_index (out_write_index),
    .out_write_byte  (out_write_byte),
    .out_entry_total (out_entry_total),
    .out_last_of_run (out_last_of_run),
    .out_line_done   (out_line_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic buf_write_t make_write(input int unsigned idx,
                                            input logic [WBYTE_W-1:0] b,
                                            input logic [TOTAL_W-1:0] total,
                                            input logic done);
    buf_write_t w;
    w.widx  = IDX_W'(idx);
    w.wbyte = b;
    w.total = total;
    w.last  = 1'b0;
    w.done  = done;
    return w;
  endfunction

  // Works out the buffer writes caused by one raw byte and queues them.
  function automatic int normalize_byte(input logic [CHAR_W-1:0] raw);
    buf_write_t run [3];
    int n;
    int unsigned p;
    logic [CHAR_W-1:0] c;
    bit full_now;
    n = 0;
    p = shadow_pos;
    c = raw;
    if (raw == CH_NUL) begin
      full_now = shadow_full || p >= LIMIT;
      if (p > LIMIT) p = LIMIT;
      if (!full_now) begin
        if (shadow_equal) begin
          shadow_entries++;
        end else if (!shadow_zero) begin
          shadow_entries++;
          run[n] = make_write(p, WB_EQUAL, shadow_entries, 1'b1);
          n++;
          p++;
        end
      end
      run[n] = make_write(p, WB_ZERO, shadow_entries, 1'b1);
      n++;
      run[n] = make_write(p + 1, WB_ZERO, shadow_entries, 1'b1);
      n++;
      shadow_pos   = p + 1;
      shadow_equal = 1'b0;
      shadow_zero  = 1'b1;
      shadow_full  = (shadow_pos >= LIMIT);
    end else if (shadow_full || p >= LIMIT) begin
      // Truncated: the byte is swallowed without touching anything else.
      shadow_full = 1'b1;
    end else begin
      if (c == CH_EQUAL) shadow_equal = 1'b1;
      if (c < CH_SPACE || c > CH_TOP) begin
        if (c == CH_NL || c == CH_CR || c == CH_TAB) c = CH_SPACE;
        else c = {1'b0, WB_DOT};
      end
      if (c == CH_SPACE) begin
        if (!shadow_zero) begin
          if (!shadow_equal && p + 1 < LIMIT) begin
            run[n] = make_write(p, WB_EQUAL, shadow_entries, 1'b0);
            n++;
            p++;
          end
          shadow_entries++;
          run[n] = make_write(p, WB_ZERO, shadow_entries, 1'b0);
          n++;
          p++;
          shadow_equal = 1'b0;
          shadow_zero  = 1'b1;
        end
      end else begin
        run[n] = make_write(p, c[WBYTE_W-1:0], shadow_entries, 1'b0);
        n++;
        p++;
        shadow_zero = 1'b0;
      end
      shadow_pos  = p;
      shadow_full = (p >= LIMIT);
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) run[i].last = 1'b1;
      pending_writes.push_back(run[i]);
    end
    return n;
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= b;
    do @(posedge clk); while (!in_ready);
    if (normalize_byte(b) > 0) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_TAB;
      1: return CH_NL;
      2: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_value_char();
    return CHAR_W'($urandom_range(33, 126));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_word_char();
    logic [CHAR_W-1:0] c;
    c = pick_value_char();
    return (c == CH_EQUAL) ? "k" : c;
  endfunction

  // Entries with random keys, optional values and runs of blanks; no terminator.
  task automatic send_entries(input int count);
    repeat ($urandom_range(0, 2)) send_byte(pick_blank());
    for (int e = 0; e < count; e++) begin
      repeat ($urandom_range(1, 6)) send_byte(pick_word_char());
      if ($urandom_range(0, 1) == 1) begin
        send_byte(CH_EQUAL);
        repeat ($urandom_range(0, 6)) send_byte(pick_value_char());
      end
      repeat ($urandom_range((e == count - 1) ? 0 : 1, 3)) send_byte(pick_blank());
    end
  endtask

  task automatic send_entry_line();
    send_entries($urandom_range(1, 4));
    send_byte(CH_NUL);
  endtask

  task automatic send_noise_line();
    repeat ($urandom_range(1, 12)) send_byte(CHAR_W'($urandom_range(1, 255)));
    send_byte(CH_NUL);
  endtask

  task automatic test_directed();
    logic [CHAR_W-1:0] pattern [] = '{
      CH_NUL,
      CH_SPACE, CH_TAB, "a", CH_EQUAL, "b", CH_SPACE, CH_SPACE, "k", CH_NL,
      "x", 8'hFF, 8'h01, CH_TOP, 8'h80, CH_CR, "z", CH_NUL,
      "q", CH_EQUAL, CH_NUL,
      "a", CH_SPACE, CH_NUL
    };
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  task automatic test_random_lines();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: send_noise_line();
        1: send_byte(CH_NUL);
        default: send_entry_line();
      endcase
    end
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_entry_line();
      wait_drained();
      send_byte(pick_word_char());
      wait_drained();
    end
  endtask

  // One long line fills the buffer; the entry is then steered to close just
  // below the limit so that the separator insertion either fits or not.
  task automatic test_buffer_full();
    int unsigned target;
    while (shadow_pos < LIMIT - 40) send_entries(1);
    send_byte(CH_SPACE);
    target = LIMIT - $urandom_range(1, 3);
    send_byte("k");
    while (shadow_pos < target) send_byte("k");
    if ($urandom_range(0, 1) == 1) send_byte(pick_blank());
    else send_byte(CH_NUL);
    repeat (8) send_byte(pick_word_char());
    send_byte(CH_EQUAL);
    send_byte(CH_NUL);
    repeat (2) send_entry_line();
    send_noise_line();
    send_byte(CH_NUL);
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] expected,
                             input logic [TOTAL_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      fail_count++;
    end
  endtask

  initial begin : write_checker
    buf_write_t want;
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_writes.size() == 0) begin
        $error("write to index %0d with nothing expected", out_write_index);
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        check_field("write_index", want.widx, out_write_index);
        check_field("write_byte", want.wbyte, out_write_byte);
        check_field("entry_total", want.total, out_entry_total);
        check_field("last_of_run", want.last, out_last_of_run);
        check_field("line_done", want.done, out_line_done);
      end
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin : main_sequence
    int waited;
    waited = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_lines();
    test_drain_pause();
    test_buffer_full();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", pending_writes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
